[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that an implication holds at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// check that a condition holds in the cycle after another
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/core/rlhc_pkg.sv]
// shared types and codes of the handle cache
package rlhc_pkg;
  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_OPEN_DONE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_FAIL = 3'd3;
  localparam logic [2:0] ST_BUSY = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int unsigned REF_BITS = 8;
  localparam int unsigned STAMP_BITS = 64;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the item
    logic scan;     // step the scan over one entry
    logic commit;   // apply the update and produce the result
  } rlhc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } rlhc_stat_t;
endpackage

[rtl/core/rlhc_ctrl.sv]
// controller state machine of the handle cache
module rlhc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rlhc_pkg::rlhc_stat_t stat_i,
  output rlhc_pkg::rlhc_cmd_t  cmd_o,
  output logic               busy_o
);
  import rlhc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_SCAN;
      S_SCAN: if (stat_i.scan_last) state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  assign cmd_o.load = (state_q == S_IDLE) && start_i;
  assign cmd_o.scan = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_COMMIT);
  assign busy_o = (state_q != S_IDLE);
endmodule

[rtl/core/rlhc_dpath.sv]
// entry state, serial scan and update logic of the handle cache
module rlhc_dpath #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned TAG_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlhc_pkg::rlhc_cmd_t cmd_i,
  output rlhc_pkg::rlhc_stat_t stat_o,
  input  logic [1:0]          op_i,
  input  logic [63:0]         key_i,
  input  logic [4:0]          entry_index_i,
  input  logic                open_ok_i,
  output logic                result_valid_o,
  output logic [2:0]          status_o,
  output logic [4:0]          slot_o
);
  import rlhc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // per-entry state in flip-flops
  logic [TAG_BITS-1:0]   tag_q   [ENTRIES];
  logic [ENTRIES-1:0]    valid_q, ready_q, opened_q;
  logic [REF_BITS-1:0]   ref_q   [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_q [ENTRIES];
  logic [STAMP_BITS-1:0] counter_q;

  // captured item and scan state
  logic [1:0]          op_q;
  logic [TAG_BITS-1:0] tag_in_q;
  logic [4:0]          idx_q;
  logic                ok_q;
  logic [CW-1:0]       pos_q;
  logic                match_q, victim_q;
  logic [IW-1:0]       match_idx_q, victim_idx_q;
  logic [STAMP_BITS-1:0] oldest_q;
  logic                rv_q;
  logic [2:0]          status_q;
  logic [4:0]          slot_q;

  logic [IW-1:0] pos_idx;
  logic          hit_here, cand_here;
  logic          idx_ok;
  logic [IW-1:0] idx_e;

  assign pos_idx = pos_q[IW-1:0];
  assign hit_here = valid_q[pos_idx] && (tag_q[pos_idx] == tag_in_q);
  assign cand_here = ready_q[pos_idx] && (ref_q[pos_idx] == '0) &&
                     (!victim_q || (stamp_q[pos_idx] < oldest_q));
  assign stat_o.scan_last = (pos_q == CW'(ENTRIES - 1)) || (op_q != OP_ACQUIRE);
  assign idx_ok = ({27'd0, idx_q} < 32'(ENTRIES));
  assign idx_e = IW'(idx_q);

  // scan over the entries, one per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      tag_in_q <= key_i[TAG_BITS-1:0];
      idx_q    <= entry_index_i;
      ok_q     <= open_ok_i;
      pos_q    <= '0;
      match_q  <= 1'b0;
      victim_q <= 1'b0;
      match_idx_q  <= '0;
      victim_idx_q <= '0;
      oldest_q <= '0;
    end else if (cmd_i.scan && op_q == OP_ACQUIRE) begin
      pos_q <= pos_q + 1'b1;
      if (!match_q && hit_here) begin
        match_q <= 1'b1;
        match_idx_q <= pos_idx;
      end
      if (cand_here) begin
        victim_q <= 1'b1;
        victim_idx_q <= pos_idx;
        oldest_q <= stamp_q[pos_idx];
      end
    end
  end

  // commit of the update and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ready_q   <= '1;
      opened_q  <= '0;
      counter_q <= '0;
      rv_q      <= 1'b0;
      status_q  <= ST_DONE;
      slot_q    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tag_q[i]   <= '0;
        ref_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      rv_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        case (op_q)
          OP_ACQUIRE: begin
            if (match_q) begin
              slot_q <= 5'(match_idx_q);
              if (!ready_q[match_idx_q]) begin
                status_q <= ST_WAIT;
              end else if (!opened_q[match_idx_q]) begin
                status_q <= ST_FAIL;
              end else begin
                status_q <= ST_HIT;
                if (ref_q[match_idx_q] != '1) begin
                  ref_q[match_idx_q] <= ref_q[match_idx_q] + 1'b1;
                end
                counter_q <= counter_q + 1'b1;
                stamp_q[match_idx_q] <= counter_q + 1'b1;
              end
            end else if (victim_q) begin
              slot_q   <= 5'(victim_idx_q);
              status_q <= ST_MISS;
              tag_q[victim_idx_q]    <= tag_in_q;
              valid_q[victim_idx_q]  <= 1'b1;
              ready_q[victim_idx_q]  <= 1'b0;
              opened_q[victim_idx_q] <= 1'b0;
            end else begin
              slot_q   <= '0;
              status_q <= ST_BUSY;
            end
          end
          OP_OPEN_DONE: begin
            slot_q <= idx_q;
            if (!idx_ok || ready_q[idx_e]) begin
              status_q <= ST_FAIL;
            end else begin
              status_q <= ST_DONE;
              ready_q[idx_e]  <= 1'b1;
              opened_q[idx_e] <= ok_q;
              ref_q[idx_e]    <= REF_BITS'(ok_q);
              if (ok_q) begin
                counter_q <= counter_q + 1'b1;
                stamp_q[idx_e] <= counter_q + 1'b1;
              end
            end
          end
          OP_RELEASE: begin
            slot_q <= idx_q;
            if (!idx_ok) begin
              status_q <= ST_FAIL;
            end else begin
              status_q <= ST_DONE;
              if (ref_q[idx_e] != '0) begin
                ref_q[idx_e] <= ref_q[idx_e] - 1'b1;
              end
            end
          end
          default: begin
            slot_q   <= '0;
            status_q <= ST_FAIL;
          end
        endcase
      end
    end
  end

  assign result_valid_o = rv_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
endmodule

[rtl/core/refcounted_lru_handle_cache_unit.sv]
// top level of the reference-counted lru handle cache
// Usage:
//   An item (op_i, key_i, entry_index_i, open_ok_i) is taken at a rising
//   edge with start high and busy low. busy stays high while it works.
//   Acquire compares the key with every entry and picks the oldest free
//   entry in one serial scan, one entry per cycle; open-done and release
//   skip the scan, as do unknown ops.
//   Flow: an item passes the scan state and then the commit state, and the
//   result is registered from the commit; ops other than acquire pass the
//   scan state without scanning. The next item may be taken in the cycle the
//   result appears. The scan over the entries sets the acquire rate.
//   Result: done_o is high for one cycle with status_o and slot_o; the
//   receiver cannot stall, so each result must be taken in that cycle.
//   Reset: all entries empty, ready and unreferenced, stamp counter at zero;
//   no result is pending and the block is ready at once.
`include "assert_macros.svh"
module refcounted_lru_handle_cache_unit #(
  parameter int unsigned ENTRIES = 32,
  parameter int unsigned TAG_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [4:0]  entry_index_i,
  input  logic        open_ok_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [4:0]  slot_o
);
  import rlhc_pkg::*;

  rlhc_cmd_t  cmd;
  rlhc_stat_t stat;

  // controller
  rlhc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // datapath
  rlhc_dpath #(
    .ENTRIES (ENTRIES),
    .TAG_BITS(TAG_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .key_i         (key_i),
    .entry_index_i (entry_index_i),
    .open_ok_i     (open_ok_i),
    .result_valid_o(done_o),
    .status_o      (status_o),
    .slot_o        (slot_o)
  );

  // checks
  `ASSERT_NEXT(a_commit_result, clk_i, rst_ni, cmd.commit, done_o)
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, done_o, status_o <= ST_DONE)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
endmodule

[tb/sv/rlhc_checker.sv]
// checker: predicts handle cache results and compares them with the block
`timescale 1ns / 1ps
module rlhc_checker #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [4:0]  entry_index_i,
  input  logic        open_ok_i,
  input  logic        done_i,
  input  logic [2:0]  status_i,
  input  logic [4:0]  slot_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  import rlhc_pkg::*;

  localparam int unsigned REF_MAX = 255;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
  } cache_resp_t;

  logic [63:0] tag_mem [ENTRIES];
  logic        tag_vld [ENTRIES];
  logic        ready_q [ENTRIES];
  logic        opened_q [ENTRIES];
  logic [7:0]  refs_q [ENTRIES];
  logic [63:0] stamp_q [ENTRIES];
  logic [63:0] stamp_ctr;
  cache_resp_t resp_q [$];

  assign pending_o = resp_q.size();

  // model of the cache: returns the answer for one item and updates state
  function automatic cache_resp_t cache_apply(logic [1:0] op, logic [63:0] key,
                                               logic [4:0] idx, logic ok);
    cache_resp_t r;
    bit found;
    bit have_v;
    int victim;
    logic [63:0] oldest;
    r = '{status: ST_FAIL, slot: 5'd0};
    found = 0;
    have_v = 0;
    victim = 0;
    oldest = '0;
    if (op == OP_ACQUIRE) begin
      for (int e = 0; e < ENTRIES && !found; e++) begin
        if (tag_vld[e] && tag_mem[e] == key) begin
          found = 1;
          r.slot = e[4:0];
          if (!ready_q[e]) r.status = ST_WAIT;
          else if (!opened_q[e]) r.status = ST_FAIL;
          else begin
            if (refs_q[e] < REF_MAX) refs_q[e] = refs_q[e] + 8'd1;
            stamp_ctr = stamp_ctr + 64'd1;
            stamp_q[e] = stamp_ctr;
            r.status = ST_HIT;
          end
        end
      end
      if (!found) begin
        for (int e = 0; e < ENTRIES; e++) begin
          if (ready_q[e] && refs_q[e] == 8'd0 && (!have_v || stamp_q[e] < oldest)) begin
            have_v = 1;
            victim = e;
            oldest = stamp_q[e];
          end
        end
        if (!have_v) begin
          r = '{status: ST_BUSY, slot: 5'd0};
        end else begin
          tag_mem[victim] = key;
          tag_vld[victim] = 1'b1;
          ready_q[victim] = 1'b0;
          opened_q[victim] = 1'b0;
          r = '{status: ST_MISS, slot: victim[4:0]};
        end
      end
    end else if (op == OP_OPEN_DONE || op == OP_RELEASE) begin
      r.slot = idx;
      if (idx >= ENTRIES) r.status = ST_FAIL;
      else if (op == OP_OPEN_DONE) begin
        if (ready_q[idx]) r.status = ST_FAIL;
        else begin
          ready_q[idx] = 1'b1;
          opened_q[idx] = ok;
          refs_q[idx] = ok ? 8'd1 : 8'd0;
          if (ok) begin
            stamp_ctr = stamp_ctr + 64'd1;
            stamp_q[idx] = stamp_ctr;
          end
          r.status = ST_DONE;
        end
      end else begin
        if (refs_q[idx] > 0) refs_q[idx] = refs_q[idx] - 8'd1;
        r.status = ST_DONE;
      end
    end
    return r;
  endfunction

  // reset state, then predict on accept and compare on done
  always @(posedge clk_i or negedge rst_ni) begin
    cache_resp_t exp_r;
    if (!rst_ni) begin
      for (int e = 0; e < ENTRIES; e++) begin
        tag_mem[e] = '0;
        tag_vld[e] = 1'b0;
        ready_q[e] = 1'b1;
        opened_q[e] = 1'b0;
        refs_q[e] = '0;
        stamp_q[e] = '0;
      end
      stamp_ctr = '0;
      resp_q.delete();
      fail_cnt_o = 0;
    end else begin
      // result first: an item may be taken in the cycle a result appears
      if (done_i) begin
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d", $time, status_i, slot_i);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          exp_r = resp_q.pop_front();
          if (status_i !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (slot_i !== exp_r.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, slot_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        resp_q.push_back(cache_apply(op_i, key_i, entry_index_i, open_ok_i));
    end
  end
endmodule

[tb/sv/tb_refcounted_lru_handle_cache_unit.sv]
// testbench top: stimulus and verdict for the handle cache
`timescale 1ns / 1ps
module tb_refcounted_lru_handle_cache_unit;
  import rlhc_pkg::*;

  // op code outside the defined set
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = OP_ACQUIRE;
  logic [63:0] key_i = '0;
  logic [4:0]  entry_index_i = '0;
  logic        open_ok_i = 1'b0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [4:0]  slot_o;
  int          fail_cnt;
  int          pending;
  int          idle_pct;
  logic [63:0] key_pool [8];

  always #2 clk_i = ~clk_i;

  refcounted_lru_handle_cache_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .key_i(key_i), .entry_index_i(entry_index_i),
    .open_ok_i(open_ok_i), .done_o(done_o), .status_o(status_o), .slot_o(slot_o)
  );

  rlhc_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .op_i(op_i), .key_i(key_i), .entry_index_i(entry_index_i),
    .open_ok_i(open_ok_i), .done_i(done_o), .status_i(status_o),
    .slot_i(slot_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // send one item: drive at the falling edge, hold until accepted
  task automatic send_item(logic [1:0] op, logic [63:0] key, logic [4:0] idx, logic ok);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    op_i = op;
    key_i = key;
    entry_index_i = idx;
    open_ok_i = ok;
    start = 1'b1;
    // busy is stable at the falling edge and holds through the next rising edge
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // random item, mostly from a small key pool so hits and waits occur
  task automatic send_random();
    int pick;
    logic [63:0] k;
    pick = $urandom_range(99);
    k = key_pool[$urandom_range(7)];
    if ($urandom_range(9) == 0) k = {$urandom, $urandom};
    if (pick < 45) send_item(OP_ACQUIRE, k, 5'($urandom), 1'($urandom));
    else if (pick < 70)
      send_item(OP_OPEN_DONE, k, 5'($urandom_range(31)), $urandom_range(3) != 0);
    else if (pick < 97)
      send_item(OP_RELEASE, k, 5'($urandom_range(31)), 1'($urandom));
    else send_item(OP_UNKNOWN, {$urandom, $urandom}, 5'($urandom), 1'($urandom));
  endtask

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    idle_pct = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: miss, wait, open ok, hit, fail path, releases, bad op
    send_item(OP_ACQUIRE, 64'd0, 5'd0, 1'b0);
    send_item(OP_ACQUIRE, 64'd0, 5'd0, 1'b0);
    send_item(OP_OPEN_DONE, 64'd0, 5'd0, 1'b1);
    send_item(OP_ACQUIRE, 64'd0, 5'd31, 1'b1);
    send_item(OP_OPEN_DONE, 64'd0, 5'd0, 1'b1);
    send_item(OP_ACQUIRE, '1, 5'd0, 1'b0);
    send_item(OP_OPEN_DONE, '1, 5'd1, 1'b0);
    send_item(OP_ACQUIRE, '1, 5'd0, 1'b0);
    send_item(OP_RELEASE, 64'd0, 5'd0, 1'b0);
    send_item(OP_RELEASE, 64'd0, 5'd0, 1'b0);
    send_item(OP_RELEASE, 64'd0, 5'd0, 1'b0);
    send_item(OP_RELEASE, 64'd0, 5'd31, 1'b1);
    send_item(OP_UNKNOWN, '1, 5'd31, 1'b1);
    // fill every entry pending, then all busy
    for (int i = 0; i < 33; i++) send_item(OP_ACQUIRE, 64'h100 + i, 5'd0, 1'b0);
    for (int i = 0; i < 32; i++) send_item(OP_OPEN_DONE, '0, i[4:0], i[0]);
    // saturate the count on one entry: open the slot that the miss claimed
    send_item(OP_ACQUIRE, 64'h55, 5'd0, 1'b0);
    while (!done_o) @(negedge clk_i);
    send_item(OP_OPEN_DONE, 64'h0, slot_o, 1'b1);
    for (int i = 0; i < 260; i++) send_item(OP_ACQUIRE, 64'h55, 5'd0, 1'b0);

    // random phases with different idling
    idle_pct = 11;
    repeat (105) send_random();
    idle_pct = 71;
    repeat (105) send_random();
    idle_pct = 0;
    repeat (105) send_random();

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/rlhc_pkg.sv
rtl/core/rlhc_ctrl.sv
rtl/core/rlhc_dpath.sv
rtl/core/refcounted_lru_handle_cache_unit.sv
tb/sv/rlhc_checker.sv
tb/sv/tb_refcounted_lru_handle_cache_unit.sv
